// ===== hw/rtl/pjc_pkg.sv =====
`default_nettype none

package pjc_pkg;

   // Fixed field widths of the item, result and register channels.
   localparam int JOINT_W   = 3;
   localparam int DATA_W    = 32;
   localparam int DT_W      = 20;
   localparam int CSR_IDX_W = 3;
   localparam int INTEG_W   = 48;

   // Defaults for the top-level parameters.
   localparam int JOINTS_DEF    = 8;
   localparam int FRAC_BITS_DEF = 16;

   // Shared divider operand widths.
   localparam int DIVD_W = 64;
   localparam int DIVS_W = 32;

   localparam logic [DT_W-1:0] US_PER_S = 20'd1000000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CONTROL_ENABLE = 3'd0,
      CSR_GAIN_P         = 3'd1,
      CSR_GAIN_I         = 3'd2,
      CSR_GAIN_D         = 3'd3,
      CSR_INTEGRAL_LIMIT = 3'd4,
      CSR_POS_TOLERANCE  = 3'd5,
      CSR_VEL_TOLERANCE  = 3'd6
   } csr_index_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_ERR,
      ST_MVD,
      ST_DV,
      ST_DVW,
      ST_MID,
      ST_DI,
      ST_DIW,
      ST_DIC,
      ST_DB,
      ST_DBW,
      ST_MP,
      ST_MD,
      ST_MIL,
      ST_MIH,
      ST_SQE,
      ST_SQV,
      ST_SQF,
      ST_TP,
      ST_TV,
      ST_SET,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic              start;
      logic [DIVD_W-1:0] dividend;
      logic [DIVS_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              busy;
      logic              done;
      logic [DIVD_W-1:0] quotient;
   } div_rsp_type;

endpackage

`default_nettype wire

// ===== hw/rtl/pjc_if.sv =====
`default_nettype none

interface pjc_req_if import pjc_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [JOINT_W-1:0]       joint;
   logic signed [DATA_W-1:0] angle;
   logic signed [DATA_W-1:0] target;
   logic [DT_W-1:0]          dt_us;
   logic                     last_joint;
   logic                     restart;

   modport source(output valid, joint, angle, target, dt_us, last_joint, restart,
                  input ready);
   modport sink(input valid, joint, angle, target, dt_us, last_joint, restart,
                output ready);
endinterface

interface pjc_rsp_if import pjc_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [JOINT_W-1:0]       joint_out;
   logic signed [DATA_W-1:0] torque;
   logic                     settled;
   logic                     last_out;

   modport source(output valid, joint_out, torque, settled, last_out, input ready);
   modport sink(input valid, joint_out, torque, settled, last_out, output ready);
endinterface

interface pjc_csr_if import pjc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [DATA_W-1:0]    data;

   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/pid_joint_controller.sv =====
`default_nettype none

// Channel    Port      Dir  Transfer carries
// ---------  --------  ---  ---------------------------------------------------
// samples    req_chan  in   joint, angle, target, dt_us, last_joint, restart
// results    rsp_chan  out  joint_out, torque, settled, last_out
// registers  csr_chan  in   index, data (always ready)
//
// A sample is taken only in the idle state, so each one is finished before the next.
// The velocity divide is skipped without a previous sample or with zero dt, the
// clamp-bound divide is skipped when gain_i is zero and the settled check runs only on
// a last joint; a joint out of range skips all but the settled check. Both divides go
// through one shared bit-serial divider, and one 33x33 multiplier serves every product,
// including the reciprocal steps that divide the integral increment by one million.
// Reset is synchronous and active high, clears all joint state and the sums and
// resets the registers. A result waits in an output register, so the next sample
// is taken even while rsp_chan is stalled; only a second result waits in the last state.

module pid_joint_controller import pjc_pkg::*; #(
   parameter int JOINTS    = JOINTS_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input logic       clock,
   input logic       reset,
   pjc_req_if.sink   req_chan,
   pjc_rsp_if.source rsp_chan,
   pjc_csr_if.sink   csr_chan
);

   localparam int IDX_W = (JOINTS > 1) ? $clog2(JOINTS) : 1;
   localparam int MUL_W = 66;
   localparam int ACC_W = 82;
   localparam logic [DATA_W-1:0] POS_TOL_RST = DATA_W'((64'd185 << FRAC_BITS) / 64'd1000);
   localparam logic [DATA_W-1:0] VEL_TOL_RST = DATA_W'((64'd1 << FRAC_BITS) / 64'd100);
   localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
   localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};
   localparam logic signed [ACC_W-1:0] T_MAX = ACC_W'(64'sh7FFF_FFFF);
   localparam logic signed [ACC_W-1:0] T_MIN = -T_MAX - ACC_W'(1);
   // One million is 15625 times 2^6. The low six bits are shifted off first, and
   // floor(2^45 / 15625) then gives a quotient estimate that is at most two too small.
   localparam logic [DATA_W-1:0] RECIP_ODD = 32'd2251799813;
   localparam logic [32:0]       ODD_DIV   = 33'd15625;

   function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? {64{1'b1}} : s[63:0];
   endfunction

   // Registers written through csr_chan.
   logic              ctl_en_ff, ctl_en_in;
   logic [DATA_W-1:0] gain_p_ff, gain_p_in, gain_i_ff, gain_i_in, gain_d_ff, gain_d_in;
   logic [DATA_W-1:0] int_lim_ff, int_lim_in, pos_tol_ff, pos_tol_in;
   logic [DATA_W-1:0] vel_tol_ff, vel_tol_in;

   // Per-joint state.
   logic signed [DATA_W-1:0]  prev_angle_ff[JOINTS], prev_angle_in[JOINTS];
   logic signed [DATA_W-1:0]  vel_ff[JOINTS], vel_in[JOINTS];
   logic signed [INTEG_W-1:0] integ_ff[JOINTS], integ_in[JOINTS];
   logic [JOINTS-1:0]         have_prev_ff, have_prev_in;
   logic [63:0]               err_sum_ff, err_sum_in, vel_sum_ff, vel_sum_in;

   // Sample being worked on.
   state_type                state_ff, state_in;
   logic [JOINT_W-1:0]       joint_ff, joint_in;
   logic signed [DATA_W-1:0] angle_ff, angle_in, target_ff, target_in;
   logic [DT_W-1:0]          dt_ff, dt_in;
   logic                     last_ff, last_in, restart_ff, restart_in;

   // Working registers.
   logic signed [DATA_W-1:0] err_ff, err_in;
   logic signed [DATA_W:0]   diff_ff, diff_in;
   logic                     take_vel_ff, take_vel_in;
   logic                     neg_ff, neg_in;
   logic signed [MUL_W-1:0]  mul_ff;
   logic signed [32:0]       mul_a, mul_b;
   logic [55:0]              lo_ff, lo_in;
   logic [DATA_W-1:0]        iq0_ff, iq0_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic                     err_ok_ff, err_ok_in;
   logic signed [DATA_W-1:0] torque_ff, torque_in;
   logic                     settled_ff, settled_in;

   // Output register.
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [JOINT_W-1:0]       rsp_joint_ff, rsp_joint_in;
   logic signed [DATA_W-1:0] rsp_torque_ff, rsp_torque_in;
   logic                     rsp_settled_ff, rsp_settled_in, rsp_last_ff, rsp_last_in;

   div_req_type div_req;
   div_rsp_type div_rsp;

   // Combinational helpers.
   logic [IDX_W-1:0]          jidx;
   logic                      in_range;
   logic signed [DATA_W:0]    err_wide;
   logic signed [DATA_W-1:0]  err_sat;
   logic signed [INTEG_W-1:0] cur_integ;
   logic signed [DATA_W-1:0]  cur_vel;
   logic [MUL_W-1:0]          mul_neg;
   logic [DIVD_W-1:0]         mul_mag;
   logic [DIVD_W-1:0]         quo;
   logic signed [DATA_W-1:0]  vel_new;
   logic [45:0]               iq_rem;
   logic [DATA_W-1:0]         iq;
   logic signed [33:0]        inc;
   logic signed [INTEG_W+1:0] integ_sum;
   logic signed [INTEG_W-1:0] bound;
   logic signed [ACC_W-1:0]   i_full;
   logic signed [ACC_W-1:0]   neg_acc;
   logic                      accept;
   logic                      rsp_load;

   pjc_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign accept   = req_chan.valid && req_chan.ready;
   assign jidx     = IDX_W'(joint_ff);
   assign in_range = (int'(joint_ff) < JOINTS);
   assign rsp_load = (state_ff == ST_FIN) && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      err_wide  = {angle_ff[DATA_W-1], angle_ff} - {target_ff[DATA_W-1], target_ff};
      if (err_wide[DATA_W] != err_wide[DATA_W-1]) begin
         err_sat = err_wide[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
      end else begin
         err_sat = err_wide[DATA_W-1:0];
      end
      cur_integ = integ_ff[jidx];
      cur_vel   = vel_ff[jidx];
      mul_neg   = -mul_ff;
      mul_mag   = mul_ff[MUL_W-1] ? mul_neg[DIVD_W-1:0] : mul_ff[DIVD_W-1:0];
      quo       = div_rsp.quotient;

      // Velocity quotient with sign restored and saturated to 32 bits.
      if (neg_ff) begin
         vel_new = (quo > 64'h8000_0000) ? 32'sh8000_0000 : $signed(~quo[31:0] + 32'd1);
      end else begin
         vel_new = (quo > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(quo[31:0]);
      end

      // The remainder left by the quotient estimate decides the final correction.
      iq_rem = lo_ff[45:0] - mul_ff[45:0];
      if (iq_rem >= 46'd31250) begin
         iq = iq0_ff + 32'd2;
      end else if (iq_rem >= 46'd15625) begin
         iq = iq0_ff + 32'd1;
      end else begin
         iq = iq0_ff;
      end
      inc       = neg_ff ? -$signed({2'b00, iq}) : $signed({2'b00, iq});
      integ_sum = (INTEG_W+2)'(cur_integ) + (INTEG_W+2)'(inc);
      bound     = (quo > {16'd0, INTEG_MAX}) ? INTEG_MAX : $signed(quo[INTEG_W-1:0]);

      // The integral term is rebuilt from its two partial products.
      i_full    = (ACC_W'(mul_ff) <<< 24) + $signed({{(ACC_W-56){1'b0}}, lo_ff});
      neg_acc   = -acc_ff;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (accept) state_in = ST_ERR;
         ST_ERR:  state_in = in_range ? ST_MVD : (last_ff ? ST_TP : ST_FIN);
         ST_MVD:  state_in = ST_DV;
         ST_DV:   state_in = take_vel_ff ? ST_DVW : ST_MID;
         ST_DVW:  if (div_rsp.done) state_in = ST_MID;
         ST_MID:  state_in = ST_DI;
         ST_DI:   state_in = ST_DIW;
         ST_DIW:  state_in = ST_DIC;
         ST_DIC:  state_in = (gain_i_ff != '0) ? ST_DB : ST_MP;
         ST_DB:   state_in = ST_DBW;
         ST_DBW:  if (div_rsp.done) state_in = ST_MP;
         ST_MP:   state_in = ST_MD;
         ST_MD:   state_in = ST_MIL;
         ST_MIL:  state_in = ST_MIH;
         ST_MIH:  state_in = ST_SQE;
         ST_SQE:  state_in = ST_SQV;
         ST_SQV:  state_in = ST_SQF;
         ST_SQF:  state_in = last_ff ? ST_TP : ST_FIN;
         ST_TP:   state_in = ST_TV;
         ST_TV:   state_in = ST_SET;
         ST_SET:  state_in = ST_FIN;
         ST_FIN:  if (rsp_load) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      ctl_en_in     = ctl_en_ff;
      gain_p_in     = gain_p_ff;
      gain_i_in     = gain_i_ff;
      gain_d_in     = gain_d_ff;
      int_lim_in    = int_lim_ff;
      pos_tol_in    = pos_tol_ff;
      vel_tol_in    = vel_tol_ff;
      prev_angle_in = prev_angle_ff;
      vel_in        = vel_ff;
      integ_in      = integ_ff;
      have_prev_in  = have_prev_ff;
      err_sum_in    = err_sum_ff;
      vel_sum_in    = vel_sum_ff;
      joint_in      = joint_ff;
      angle_in      = angle_ff;
      target_in     = target_ff;
      dt_in         = dt_ff;
      last_in       = last_ff;
      restart_in    = restart_ff;
      err_in        = err_ff;
      diff_in       = diff_ff;
      take_vel_in   = take_vel_ff;
      neg_in        = neg_ff;
      lo_in         = lo_ff;
      iq0_in        = iq0_ff;
      acc_in        = acc_ff;
      err_ok_in     = err_ok_ff;
      torque_in     = torque_ff;
      settled_in    = settled_ff;
      mul_a         = '0;
      mul_b         = '0;
      div_req       = '{start: 1'b0, dividend: '0, divisor: '0};

      if (csr_chan.valid) begin
         case (csr_index_type'(csr_chan.index))
            CSR_CONTROL_ENABLE: ctl_en_in  = csr_chan.data[0];
            CSR_GAIN_P:         gain_p_in  = csr_chan.data;
            CSR_GAIN_I:         gain_i_in  = csr_chan.data;
            CSR_GAIN_D:         gain_d_in  = csr_chan.data;
            CSR_INTEGRAL_LIMIT: int_lim_in = csr_chan.data;
            CSR_POS_TOLERANCE:  pos_tol_in = csr_chan.data;
            CSR_VEL_TOLERANCE:  vel_tol_in = csr_chan.data;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               joint_in   = req_chan.joint;
               angle_in   = req_chan.angle;
               target_in  = req_chan.target;
               dt_in      = req_chan.dt_us;
               last_in    = req_chan.last_joint;
               restart_in = req_chan.restart;
            end
         end
         ST_ERR: begin
            // A restart drops the integral and the previous sample first.
            err_in      = err_sat;
            diff_in     = {angle_ff[DATA_W-1], angle_ff} -
                          {prev_angle_ff[jidx][DATA_W-1], prev_angle_ff[jidx]};
            take_vel_in = have_prev_ff[jidx] && !restart_ff && (dt_ff != '0);
            torque_in   = '0;
            settled_in  = 1'b0;
            if (in_range && restart_ff) begin
               integ_in[jidx]     = '0;
               have_prev_in[jidx] = 1'b0;
            end
         end
         ST_MVD: begin
            mul_a = diff_ff;
            mul_b = 33'(US_PER_S);
         end
         ST_DV: begin
            div_req = '{start: take_vel_ff, dividend: mul_mag, divisor: DIVS_W'(dt_ff)};
            neg_in  = mul_ff[MUL_W-1];
            prev_angle_in[jidx] = angle_ff;
            have_prev_in[jidx]  = 1'b1;
         end
         ST_DVW: begin
            if (div_rsp.done) vel_in[jidx] = vel_new;
         end
         ST_MID: begin
            mul_a = {err_ff[DATA_W-1], err_ff};
            mul_b = 33'(dt_ff);
         end
         ST_DI: begin
            // The magnitude of err * dt stays below 2^51, so after the shift by six
            // its top 32 of 45 bits feed the reciprocal estimate.
            lo_in  = {11'd0, mul_mag[50:6]};
            neg_in = mul_ff[MUL_W-1];
            mul_a  = {1'b0, mul_mag[50:19]};
            mul_b  = {1'b0, RECIP_ODD};
         end
         ST_DIW: begin
            iq0_in = mul_ff[63:32];
            mul_a  = {1'b0, mul_ff[63:32]};
            mul_b  = ODD_DIV;
         end
         ST_DIC: begin
            if (integ_sum > (INTEG_W+2)'(INTEG_MAX)) begin
               integ_in[jidx] = INTEG_MAX;
            end else if (integ_sum < (INTEG_W+2)'(INTEG_MIN)) begin
               integ_in[jidx] = INTEG_MIN;
            end else begin
               integ_in[jidx] = integ_sum[INTEG_W-1:0];
            end
         end
         ST_DB: begin
            div_req = '{start: 1'b1, dividend: DIVD_W'(int_lim_ff) << FRAC_BITS,
                        divisor: gain_i_ff};
         end
         ST_DBW: begin
            if (div_rsp.done) begin
               if (cur_integ > bound) begin
                  integ_in[jidx] = bound;
               end else if (cur_integ < -bound) begin
                  integ_in[jidx] = -bound;
               end
            end
         end
         ST_MP: begin
            acc_in = '0;
            mul_a  = {1'b0, gain_p_ff};
            mul_b  = {err_ff[DATA_W-1], err_ff};
         end
         ST_MD: begin
            acc_in = acc_ff + ACC_W'(mul_ff >>> FRAC_BITS);
            mul_a  = {1'b0, gain_d_ff};
            mul_b  = {cur_vel[DATA_W-1], cur_vel};
         end
         ST_MIL: begin
            acc_in = acc_ff + ACC_W'(mul_ff >>> FRAC_BITS);
            mul_a  = {1'b0, gain_i_ff};
            mul_b  = {9'd0, cur_integ[23:0]};
         end
         ST_MIH: begin
            lo_in = mul_ff[55:0];
            mul_a = {1'b0, gain_i_ff};
            mul_b = 33'($signed(cur_integ[INTEG_W-1:24]));
         end
         ST_SQE: begin
            acc_in = acc_ff + (i_full >>> FRAC_BITS);
            mul_a  = {err_ff[DATA_W-1], err_ff};
            mul_b  = {err_ff[DATA_W-1], err_ff};
         end
         ST_SQV: begin
            err_sum_in = add_sat(err_sum_ff, mul_ff[63:0]);
            mul_a      = {cur_vel[DATA_W-1], cur_vel};
            mul_b      = {cur_vel[DATA_W-1], cur_vel};
         end
         ST_SQF: begin
            vel_sum_in = add_sat(vel_sum_ff, mul_ff[63:0]);
            if (!ctl_en_ff) begin
               torque_in = '0;
            end else if (neg_acc > T_MAX) begin
               torque_in = T_MAX[DATA_W-1:0];
            end else if (neg_acc < T_MIN) begin
               torque_in = T_MIN[DATA_W-1:0];
            end else begin
               torque_in = neg_acc[DATA_W-1:0];
            end
         end
         ST_TP: begin
            mul_a = {1'b0, pos_tol_ff};
            mul_b = {1'b0, pos_tol_ff};
         end
         ST_TV: begin
            err_ok_in = (err_sum_ff < mul_ff[63:0]);
            mul_a     = {1'b0, vel_tol_ff};
            mul_b     = {1'b0, vel_tol_ff};
         end
         ST_SET: begin
            // With control off the vector always counts as settled.
            settled_in = ctl_en_ff ? (err_ok_ff && (vel_sum_ff < mul_ff[63:0])) : 1'b1;
            err_sum_in = '0;
            vel_sum_in = '0;
         end
         ST_FIN: ;
         default: ;
      endcase

      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_joint_in   = rsp_joint_ff;
      rsp_torque_in  = rsp_torque_ff;
      rsp_settled_in = rsp_settled_ff;
      rsp_last_in    = rsp_last_ff;
      if (rsp_load) begin
         rsp_valid_in   = 1'b1;
         rsp_joint_in   = joint_ff;
         rsp_torque_in  = torque_ff;
         rsp_settled_in = settled_ff;
         rsp_last_in    = last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         ctl_en_ff     <= 1'b0;
         gain_p_ff     <= '0;
         gain_i_ff     <= '0;
         gain_d_ff     <= '0;
         int_lim_ff    <= '0;
         pos_tol_ff    <= POS_TOL_RST;
         vel_tol_ff    <= VEL_TOL_RST;
         have_prev_ff  <= '0;
         err_sum_ff    <= '0;
         vel_sum_ff    <= '0;
         for (int i = 0; i < JOINTS; i++) begin
            prev_angle_ff[i] <= '0;
            vel_ff[i]        <= '0;
            integ_ff[i]      <= '0;
         end
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         ctl_en_ff     <= ctl_en_in;
         gain_p_ff     <= gain_p_in;
         gain_i_ff     <= gain_i_in;
         gain_d_ff     <= gain_d_in;
         int_lim_ff    <= int_lim_in;
         pos_tol_ff    <= pos_tol_in;
         vel_tol_ff    <= vel_tol_in;
         have_prev_ff  <= have_prev_in;
         err_sum_ff    <= err_sum_in;
         vel_sum_ff    <= vel_sum_in;
         prev_angle_ff <= prev_angle_in;
         vel_ff        <= vel_in;
         integ_ff      <= integ_in;
      end
      joint_ff       <= joint_in;
      angle_ff       <= angle_in;
      target_ff      <= target_in;
      dt_ff          <= dt_in;
      last_ff        <= last_in;
      restart_ff     <= restart_in;
      err_ff         <= err_in;
      diff_ff        <= diff_in;
      take_vel_ff    <= take_vel_in;
      neg_ff         <= neg_in;
      mul_ff         <= mul_a * mul_b;
      lo_ff          <= lo_in;
      iq0_ff         <= iq0_in;
      acc_ff         <= acc_in;
      err_ok_ff      <= err_ok_in;
      torque_ff      <= torque_in;
      settled_ff     <= settled_in;
      rsp_joint_ff   <= rsp_joint_in;
      rsp_torque_ff  <= rsp_torque_in;
      rsp_settled_ff <= rsp_settled_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign req_chan.ready     = (state_ff == ST_IDLE);
   assign csr_chan.ready     = 1'b1;
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.joint_out = rsp_joint_ff;
   assign rsp_chan.torque    = rsp_torque_ff;
   assign rsp_chan.settled   = rsp_settled_ff;
   assign rsp_chan.last_out  = rsp_last_ff;

   // An accepted sample always starts its work in the next cycle.
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_ERR)
      else $error("accepted sample did not start");

   // The shared divider is never restarted while it still works.
   a_div_free: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_rsp.busy)
      else $error("divider started while busy");

   // A joint beyond the table drives no torque.
   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && (int'(rsp_chan.joint_out) >= JOINTS) |-> rsp_chan.torque == '0)
      else $error("out-of-range joint drove torque");

   // Settled is only reported on the last joint of a vector.
   a_settled_last: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.last_out |-> !rsp_chan.settled)
      else $error("settled flagged on a non-final joint");

endmodule

`default_nettype wire

// ===== hw/rtl/pjc_divider.sv =====
`default_nettype none

// Restoring unsigned divider, one quotient bit per cycle.
module pjc_divider import pjc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   localparam int CNT_W = $clog2(DIVD_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [DIVS_W-1:0] rem_ff, rem_in;
   logic [DIVS_W-1:0] dsr_ff, dsr_in;
   logic [DIVD_W-1:0] quo_ff, quo_in;
   logic [DIVS_W:0]   trial;
   logic [DIVS_W:0]   diff;
   logic              fits;

   always_comb begin
      trial    = {rem_ff, quo_ff[DIVD_W-1]};
      diff     = trial - {1'b0, dsr_ff};
      fits     = (trial >= {1'b0, dsr_ff});
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      dsr_in   = dsr_ff;
      quo_in   = quo_ff;
      if (div_req.start) begin
         busy_in  = 1'b1;
         count_in = CNT_W'(DIVD_W - 1);
         rem_in   = '0;
         dsr_in   = div_req.divisor;
         quo_in   = div_req.dividend;
      end else if (busy_ff) begin
         rem_in   = fits ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
         quo_in   = {quo_ff[DIVD_W-2:0], fits};
         count_in = count_ff - CNT_W'(1);
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
   end

   assign div_rsp = '{busy: busy_ff, done: done_ff, quotient: quo_ff};

endmodule

`default_nettype wire
